FILE: sv/sink_pkg.sv
// Shared types and constants for the sorted insert / nearest key block.
// No dependencies; imported by sink_ctrl, sink_dp and sorted_insert_nearest_key.
`default_nettype none
package sink_pkg;

  localparam int unsigned KEY_W    = 30;
  localparam int unsigned IDENT_W  = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 31;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_KEY   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_IDENT = 1'd1;

  localparam logic [KEY_W-1:0]   SEED_KEY_RST   = 30'd1000000000;
  localparam logic [IDENT_W-1:0] SEED_IDENT_RST = 31'd1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [IDENT_W-1:0] member_ident;
    logic [KEY_W-1:0]   member_key;
  } req_t;

  typedef struct packed {
    logic [IDENT_W-1:0]  newcomer_ident;
    logic [IDENT_W-1:0]  opponent_ident;
    logic [STATUS_W-1:0] status;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_cmp;
    logic pred_rd;
    logic pred_cap;
    logic succ_rd;
    logic succ_cap;
    logic diff;
    logic result;
    logic sh_rd;
    logic sh_wr;
    logic ins;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dup;
    logic lo_lt_hi;
    logic pos_nz;
    logic pos_lt_cnt;
    logic j_gt_pos;
    logic full;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/sink_ctrl.sv
// Sequencer for the sorted insert block: search, neighbor fetch, result, shift, insert.
// Depends on sink_pkg for the command and status structs.
`default_nettype none
module sink_ctrl
  import sink_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SRCH_RD  = 4'd1;
  localparam logic [3:0] S_SRCH_CMP = 4'd2;
  localparam logic [3:0] S_PRED_RD  = 4'd3;
  localparam logic [3:0] S_PRED_CAP = 4'd4;
  localparam logic [3:0] S_SUCC_RD  = 4'd5;
  localparam logic [3:0] S_SUCC_CAP = 4'd6;
  localparam logic [3:0] S_DIST     = 4'd7;
  localparam logic [3:0] S_RESULT   = 4'd8;
  localparam logic [3:0] S_SH_RD    = 4'd9;
  localparam logic [3:0] S_SH_WR    = 4'd10;
  localparam logic [3:0] S_INS      = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (sts_i.dup) begin
          state_d = S_DIST;
        end else if (sts_i.lo_lt_hi) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end else begin
          state_d = S_PRED_RD;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCH_RD;
      end
      S_PRED_RD: begin
        if (sts_i.pos_nz) begin
          cmd_o.pred_rd = 1'b1;
          state_d       = S_PRED_CAP;
        end else begin
          state_d = S_SUCC_RD;
        end
      end
      S_PRED_CAP: begin
        cmd_o.pred_cap = 1'b1;
        state_d        = S_SUCC_RD;
      end
      S_SUCC_RD: begin
        if (sts_i.pos_lt_cnt) begin
          cmd_o.succ_rd = 1'b1;
          state_d       = S_SUCC_CAP;
        end else begin
          state_d = S_DIST;
        end
      end
      S_SUCC_CAP: begin
        cmd_o.succ_cap = 1'b1;
        state_d        = S_DIST;
      end
      S_DIST: begin
        cmd_o.diff = 1'b1;
        state_d    = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = (!sts_i.dup && !sts_i.full) ? S_SH_RD : S_IDLE;
      end
      S_SH_RD: begin
        if (sts_i.j_gt_pos) begin
          cmd_o.sh_rd = 1'b1;
          state_d     = S_SH_WR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = S_SH_RD;
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/sink_dp.sv
// Datapath of the sorted insert block: seed registers, key/ident table memory,
// binary search bounds, neighbor registers and the result register. Uses sink_pkg.
`default_nettype none
module sink_dp
  import sink_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i,
  input  req_t                  req_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  done_o,
  output res_t                  res_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W-1:0]   seed_key_q;
  logic [IDENT_W-1:0] seed_ident_q;

  logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
  logic [IDENT_W-1:0] id_mem  [TABLE_DEPTH];
  logic [KEY_W-1:0]   rd_key_q;
  logic [IDENT_W-1:0] rd_id_q;

  logic [CW-1:0] count_q, lo_q, hi_q, mid_q, j_q;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;

  logic [KEY_W-1:0]   key_q, pred_key_q, succ_key_q, dp_q, ds_q;
  logic [IDENT_W-1:0] ident_q, pred_id_q, succ_id_q;
  logic               has_pred_q, has_succ_q, dup_q;

  logic          rd_en, wr_en;
  logic [CW-1:0] rd_idx, wr_idx;
  logic [KEY_W-1:0]   wr_key;
  logic [IDENT_W-1:0] wr_id;
  logic [IDENT_W-1:0] opponent;
  logic [STATUS_W-1:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_key_q   <= SEED_KEY_RST;
      seed_ident_q <= SEED_IDENT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEED_KEY:   seed_key_q   <= cfg_data_i[KEY_W-1:0];
        CFG_SEED_IDENT: seed_ident_q <= cfg_data_i[IDENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];

  always_comb begin
    rd_en  = cmd_i.srch_rd | cmd_i.pred_rd | cmd_i.succ_rd | cmd_i.sh_rd;
    rd_idx = mid;
    if (cmd_i.pred_rd) begin
      rd_idx = lo_q - CW'(1);
    end else if (cmd_i.succ_rd) begin
      rd_idx = lo_q;
    end else if (cmd_i.sh_rd) begin
      rd_idx = j_q - CW'(1);
    end
  end

  always_comb begin
    wr_en  = cmd_i.sh_wr | cmd_i.ins;
    wr_idx = j_q;
    wr_key = rd_key_q;
    wr_id  = rd_id_q;
    if (cmd_i.ins) begin
      wr_idx = lo_q;
      wr_key = key_q;
      wr_id  = ident_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_idx[AW-1:0]] <= wr_key;
      id_mem[wr_idx[AW-1:0]]  <= wr_id;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_idx[AW-1:0]];
      rd_id_q  <= id_mem[rd_idx[AW-1:0]];
    end
  end

  // Request key and ident, search bounds, neighbors, distances and the insert cursor.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q      <= req_i.member_key;
      ident_q    <= req_i.member_ident;
      lo_q       <= '0;
      hi_q       <= count_q;
      has_pred_q <= (seed_key_q < req_i.member_key);
      has_succ_q <= (seed_key_q > req_i.member_key);
      pred_key_q <= seed_key_q;
      pred_id_q  <= seed_ident_q;
      succ_key_q <= seed_key_q;
      succ_id_q  <= seed_ident_q;
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid;
    end
    if (cmd_i.srch_cmp) begin
      if (rd_key_q < key_q) begin
        lo_q <= mid_q + CW'(1);
      end else if (rd_key_q > key_q) begin
        hi_q <= mid_q;
      end
    end
    // The seed was loaded first and wins when keys are equal.
    if (cmd_i.pred_cap && (!has_pred_q || rd_key_q > pred_key_q)) begin
      has_pred_q <= 1'b1;
      pred_key_q <= rd_key_q;
      pred_id_q  <= rd_id_q;
    end
    if (cmd_i.succ_cap && (!has_succ_q || rd_key_q < succ_key_q)) begin
      has_succ_q <= 1'b1;
      succ_key_q <= rd_key_q;
      succ_id_q  <= rd_id_q;
    end
    if (cmd_i.diff) begin
      dp_q <= key_q - pred_key_q;
      ds_q <= succ_key_q - key_q;
    end
    if (cmd_i.result) begin
      j_q <= count_q;
    end else if (cmd_i.sh_wr) begin
      j_q <= j_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dup_q   <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      done_o <= cmd_i.result;
      if (cmd_i.load) begin
        dup_q <= (seed_key_q == req_i.member_key);
      end else if (cmd_i.srch_cmp && rd_key_q == key_q) begin
        dup_q <= 1'b1;
      end
      if (cmd_i.ins) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  always_comb begin
    if (dup_q) begin
      opponent = '0;
    end else if (!has_pred_q) begin
      opponent = succ_id_q;
    end else if (!has_succ_q) begin
      opponent = pred_id_q;
    end else if (dp_q <= ds_q) begin
      opponent = pred_id_q;
    end else begin
      opponent = succ_id_q;
    end
    if (dup_q) begin
      status = ST_DUP;
    end else if (sts_o.full) begin
      status = ST_FULL;
    end else begin
      status = ST_INSERTED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      res_o.newcomer_ident <= ident_q;
      res_o.opponent_ident <= opponent;
      res_o.status         <= status;
    end
  end

  assign sts_o.dup        = dup_q;
  assign sts_o.lo_lt_hi   = (lo_q < hi_q);
  assign sts_o.pos_nz     = (lo_q != '0);
  assign sts_o.pos_lt_cnt = (lo_q < count_q);
  assign sts_o.j_gt_pos   = (j_q > lo_q);
  assign sts_o.full       = (count_q == CW'(TABLE_DEPTH));

endmodule
`default_nettype wire

FILE: sv/sorted_insert_nearest_key.sv
// done_o rises once per request, after the binary search (at most floor(log2(N))+1 steps
// for N stored entries), the neighbor fetches and the distance and result states; a
// seed-key duplicate skips the search and neighbor fetches and goes to the distance state.
// Before an insert, entries above the slot move up one at a time, each by a read and a write
// state, so busy stays high past the strobe; one request at a time. No receiver stall.
// Reset empties the table (fill count zero) and loads the seed registers; no clearing pass.
`default_nettype none
module sorted_insert_nearest_key
  import sink_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // Request side: a request is taken when start is high while busy is low.
  input  wire                   start,
  output logic                  busy,
  input  req_t                  req_i,
  // Result side: one strobe per request.
  output logic                  done_o,
  output res_t                  res_o,
  // Configuration writes, seed key at index 0 and seed ident at index 1.
  input  wire                   cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // The controller walks each request through a binary search of the sorted table,
  // fetches the stored neighbors on either side of the insertion slot, merges them with
  // the seed member, reports the nearest one and, unless the key is a duplicate or the
  // table is full, moves the upper entries up one place and writes the new pair.
  sink_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // The datapath owns the table memory, the seed registers and all search state.
  sink_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  // An accepted request always occupies the block in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  // A result strobe is never followed directly by another.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // A dropped duplicate never names an opponent.
  a_dup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status == ST_DUP) |-> (res_o.opponent_ident == '0))
    else $error("duplicate result with nonzero opponent");

  // Only the three defined status codes appear.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.status == ST_INSERTED || res_o.status == ST_DUP ||
                res_o.status == ST_FULL))
    else $error("undefined status code");

endmodule
`default_nettype wire
